FILE: rtl/charlieplex_led_pwm_scanner_core_macros.svh
// Assertion macros used by the checker file of the scanner core.
// Each expects signals named clk and arst_n in the scope where it is used.
`ifndef CHARLIEPLEX_LED_PWM_SCANNER_CORE_MACROS_SVH
`define CHARLIEPLEX_LED_PWM_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define CLPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: rtl/clps_pkg.sv
package clps_pkg;

	// Sizing of the LED group and the slot timer.
	localparam int MAX_LEDS   = 12;
	localparam int TIMER_BITS = 16;

	// Widths fixed by the item fields.
	localparam int OP_W       = 3;
	localparam int LED_W      = 4;
	localparam int DUTY_W     = 8;
	localparam int FRAMES_W   = 16;
	localparam int TICKS_W    = 16;
	localparam int LINE_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int MEM_AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int PROD_W = TICKS_W + DUTY_W;
	localparam int THR_W  = TIMER_BITS + DUTY_W + 1;
	localparam int CMP_W  = (PROD_W > THR_W) ? PROD_W : THR_W;
	localparam int LEN_W  = ((TIMER_BITS + 1) > (TICKS_W + 1)) ? (TIMER_BITS + 1) : (TICKS_W + 1);

	localparam int FULL_DUTY      = 255;
	localparam int LAST_POS_THREE = 3 * 2 - 1;
	localparam int LAST_POS_FOUR  = 4 * 3 - 1;

	localparam logic [TICKS_W-1:0] CYCLE_TICKS_RESET = TICKS_W'(1000);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 3'd1;
	localparam logic [OP_W-1:0] OP_START   = 3'd2;
	localparam logic [OP_W-1:0] OP_HOLD    = 3'd3;
	localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

	// Run modes.
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_PLAY  = 2'd1;
	localparam logic [1:0] MODE_BLANK = 2'd2;
	localparam logic [1:0] MODE_HOLD  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_LINES  = 2'd1;

	typedef struct packed {
		logic [1:0]            mode;
		logic [LED_W-1:0]      pos;
		logic [TIMER_BITS-1:0] timer;
		logic [FRAMES_W-1:0]   frames;
		logic [LED_W-1:0]      held;
	} scan_state_t;

	function automatic logic [LED_W:0] led_count(input logic four);
		logic [LED_W:0] n;
		n = four ? (LED_W+1)'(LAST_POS_FOUR + 1) : (LED_W+1)'(LAST_POS_THREE + 1);
		if (n > (LED_W+1)'(MAX_LEDS)) begin
			n = (LED_W+1)'(MAX_LEDS);
		end
		return n;
	endfunction

	function automatic logic [1:0] anode_of(input logic [LED_W-1:0] led);
		logic [1:0] a;
		case (led)
			4'd0:    a = 2'd0;
			4'd1:    a = 2'd1;
			4'd2:    a = 2'd0;
			4'd3:    a = 2'd2;
			4'd4:    a = 2'd1;
			4'd5:    a = 2'd2;
			4'd6:    a = 2'd0;
			4'd7:    a = 2'd3;
			4'd8:    a = 2'd1;
			4'd9:    a = 2'd3;
			4'd10:   a = 2'd2;
			4'd11:   a = 2'd3;
			default: a = 2'd0;
		endcase
		return a;
	endfunction

	function automatic logic [1:0] cathode_of(input logic [LED_W-1:0] led);
		logic [1:0] k;
		case (led)
			4'd0:    k = 2'd1;
			4'd1:    k = 2'd0;
			4'd2:    k = 2'd2;
			4'd3:    k = 2'd0;
			4'd4:    k = 2'd2;
			4'd5:    k = 2'd1;
			4'd6:    k = 2'd3;
			4'd7:    k = 2'd0;
			4'd8:    k = 2'd3;
			4'd9:    k = 2'd1;
			4'd10:   k = 2'd3;
			4'd11:   k = 2'd2;
			default: k = 2'd0;
		endcase
		return k;
	endfunction

	// Returns {line_high, line_enable} for one lit LED, all released when out of range.
	function automatic logic [2*LINE_W-1:0] led_lines(input logic [LED_W-1:0] led,
			input logic four);
		logic [LINE_W-1:0] hi;
		logic [LINE_W-1:0] en;
		logic [1:0]        a;
		logic [1:0]        k;
		hi = '0;
		en = '0;
		a  = anode_of(led);
		k  = cathode_of(led);
		if ({1'b0, led} < led_count(four)) begin
			hi[a] = 1'b1;
			en[a] = 1'b1;
			en[k] = 1'b1;
		end
		return {hi, en};
	endfunction

endpackage

FILE: rtl/clps_duty_mem.sv
module clps_duty_mem import clps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [LED_W-1:0]  wr_addr,
	input  logic [DUTY_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [LED_W-1:0]  rd_addr,
	output logic [DUTY_W-1:0] rd_data
);

	logic [DUTY_W-1:0] mem_q [MAX_LEDS];
	logic [MAX_LEDS-1:0] vld_q;
	logic [DUTY_W-1:0] rd_data_q;
	logic              wr_ok;
	logic              rd_ok;
	logic [MEM_AW-1:0] wa;
	logic [MEM_AW-1:0] ra;

	assign wr_ok = wr_en && ({1'b0, wr_addr} < (LED_W+1)'(MAX_LEDS));
	assign rd_ok = {1'b0, rd_addr} < (LED_W+1)'(MAX_LEDS);
	assign wa    = wr_addr[MEM_AW-1:0];
	assign ra    = rd_addr[MEM_AW-1:0];

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_ok) begin
			vld_q[wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wa] <= wr_data;
		end
	end

	// A write in the same cycle to the entry being read is forwarded.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (!rd_ok) begin
				rd_data_q <= '0;
			end else if (wr_ok && (wa == ra)) begin
				rd_data_q <= wr_data;
			end else if (vld_q[ra]) begin
				rd_data_q <= mem_q[ra];
			end else begin
				rd_data_q <= '0;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/clps_ctrl.sv
module clps_ctrl import clps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [OP_W-1:0]     operation,
	input  logic [LED_W-1:0]    led_index,
	input  logic [FRAMES_W-1:0] repeat_count,
	input  logic [TICKS_W-1:0]  cycle_ticks,
	input  logic                four_lines,
	output scan_state_t         st_next
);

	scan_state_t           st_q;
	scan_state_t           st_n;
	logic [TIMER_BITS:0]   t1;
	logic [LEN_W-1:0]      slot_len;
	logic                  slot_end;
	logic [LED_W:0]        pos_inc;
	logic [LED_W:0]        cnt;

	always_comb begin
		cnt      = led_count(four_lines);
		t1       = {1'b0, st_q.timer} + 1'b1;
		slot_len = (cycle_ticks == '0) ? LEN_W'(1) : LEN_W'(cycle_ticks);
		if (slot_len > (LEN_W'(1) << TIMER_BITS)) begin
			slot_len = LEN_W'(1) << TIMER_BITS;
		end
		slot_end = LEN_W'(t1) >= slot_len;
		pos_inc  = {1'b0, st_q.pos} + 1'b1;
		st_n     = st_q;
		if (accept) begin
			unique case (operation)
				OP_TICK: begin
					if ((st_q.mode == MODE_PLAY) || (st_q.mode == MODE_BLANK)) begin
						if (!slot_end) begin
							st_n.timer = t1[TIMER_BITS-1:0];
						end else begin
							st_n.timer = '0;
							if (pos_inc < cnt) begin
								st_n.pos = pos_inc[LED_W-1:0];
							end else begin
								st_n.pos = '0;
								if (st_q.mode == MODE_PLAY) begin
									if (st_q.frames == '0) begin
										st_n.mode = MODE_BLANK;
									end else begin
										st_n.frames = st_q.frames - 1'b1;
									end
								end else begin
									st_n.mode = MODE_IDLE;
								end
							end
						end
					end
				end
				OP_LOAD: begin
					st_n = st_q;
				end
				OP_START: begin
					st_n.frames = (repeat_count == '0) ? '0 : repeat_count - 1'b1;
					st_n.timer  = '0;
					st_n.pos    = '0;
					st_n.mode   = MODE_PLAY;
				end
				OP_HOLD: begin
					st_n.frames = '0;
					st_n.timer  = '0;
					st_n.pos    = '0;
					st_n.held   = led_index;
					st_n.mode   = ({1'b0, led_index} < cnt) ? MODE_HOLD : MODE_IDLE;
				end
				OP_RELEASE: begin
					st_n.frames = '0;
					st_n.timer  = '0;
					st_n.pos    = '0;
					st_n.mode   = MODE_IDLE;
				end
				default: begin
					st_n = st_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode   <= MODE_IDLE;
			st_q.pos    <= '0;
			st_q.timer  <= '0;
			st_q.frames <= '0;
			st_q.held   <= '0;
		end else if (accept) begin
			st_q <= st_n;
		end
	end

	assign st_next = st_n;

endmodule

FILE: rtl/clps_drive.sv
module clps_drive import clps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                v_s1,
	input  scan_state_t         st_s1,
	input  logic [DUTY_W-1:0]   duty_s1,
	input  logic [TICKS_W-1:0]  cycle_ticks,
	input  logic                four_lines,
	input  logic                out_stall,
	output logic                hold_s2,
	output logic                out_valid,
	output logic [LINE_W-1:0]   line_high,
	output logic [LINE_W-1:0]   line_enable,
	output logic [LED_W-1:0]    current_led,
	output logic [FRAMES_W-1:0] frames_left,
	output logic                busy_res,
	output logic                blanking
);

	logic                  v_s2;
	scan_state_t           st_s2;
	logic [PROD_W-1:0]     prod_s2;
	logic [THR_W-1:0]      thr_s2;
	logic [THR_W-1:0]      t1;
	logic                  hold_s3;
	logic                  lit;
	logic [2*LINE_W-1:0]   lines;
	logic [LED_W-1:0]      cur;

	logic                  v_s3;
	logic [LINE_W-1:0]     line_high_s3;
	logic [LINE_W-1:0]     line_enable_s3;
	logic [LED_W-1:0]      current_led_s3;
	logic [FRAMES_W-1:0]   frames_left_s3;
	logic                  busy_s3;
	logic                  blanking_s3;

	assign hold_s3 = v_s3 && out_stall;
	assign hold_s2 = v_s2 && hold_s3;

	// The slot is lit while timer < floor(ticks*duty/255), that is 255*(timer+1) <= ticks*duty.
	assign t1 = THR_W'(st_s1.timer) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!hold_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s2 && v_s1) begin
			st_s2   <= st_s1;
			prod_s2 <= PROD_W'(cycle_ticks) * PROD_W'(duty_s1);
			thr_s2  <= (t1 << DUTY_W) - t1;
		end
	end

	always_comb begin
		lit   = CMP_W'(prod_s2) >= CMP_W'(thr_s2);
		lines = '0;
		cur   = '0;
		case (st_s2.mode)
			MODE_PLAY: begin
				if (lit) begin
					lines = led_lines(st_s2.pos, four_lines);
				end
				cur = st_s2.pos;
			end
			MODE_BLANK: cur = st_s2.pos;
			MODE_HOLD: begin
				lines = led_lines(st_s2.held, four_lines);
				cur   = st_s2.held;
			end
			default: cur = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (!hold_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s3 && v_s2) begin
			line_high_s3   <= lines[2*LINE_W-1:LINE_W];
			line_enable_s3 <= lines[LINE_W-1:0];
			current_led_s3 <= cur;
			frames_left_s3 <= (st_s2.mode == MODE_PLAY) ? st_s2.frames : '0;
			busy_s3        <= (st_s2.mode == MODE_PLAY) || (st_s2.mode == MODE_BLANK);
			blanking_s3    <= st_s2.mode == MODE_BLANK;
		end
	end

	assign out_valid   = v_s3;
	assign line_high   = line_high_s3;
	assign line_enable = line_enable_s3;
	assign current_led = current_led_s3;
	assign frames_left = frames_left_s3;
	assign busy_res    = busy_s3;
	assign blanking    = blanking_s3;

endmodule

FILE: rtl/charlieplex_led_pwm_scanner_core.sv
// Charlieplexed LED PWM scanner core.
// Input channel (in_valid/in_stall): one item per transfer carrying an operation
// (tick, load duty, start group, hold one LED, release all), an LED index, a duty
// and a repeat count. Every input transfer yields exactly one result transfer on
// the output channel (out_valid/out_stall) showing the line drive and scan state
// after that item.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 sets the ticks per
// LED slot, index 1 chooses four lines (twelve LEDs) or three lines (six LEDs).
// Writes must be made only while the block is idle; the block does not enforce it.
// Throughput is one item per cycle unless the output stalls. The scan state sits
// in registers updated at the input transfer, the duty store is a small
// synchronous memory with a registered read, then a multiply stage and the output
// register follow.
// Reset clears the duty store (through per-entry valid bits), the scan state and
// the pipeline, and restores 1000 ticks per slot in four-line mode; no clearing
// pass is needed, so items are accepted straight after reset.
// When the receiver stalls, the result holds in the output register and the stages
// behind it keep filling; in_stall rises only once all three stages are occupied.
module charlieplex_led_pwm_scanner_core import clps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input item channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OP_W-1:0]       operation,
	input  logic [LED_W-1:0]      led_index,
	input  logic [DUTY_W-1:0]     duty,
	input  logic [FRAMES_W-1:0]   repeat_count,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LINE_W-1:0]     line_high,
	output logic [LINE_W-1:0]     line_enable,
	output logic [LED_W-1:0]      current_led,
	output logic [FRAMES_W-1:0]   frames_left,
	output logic                  busy_res,
	output logic                  blanking
);

	logic [TICKS_W-1:0] cycle_ticks_q;
	logic               four_lines_q;
	logic               accept;
	logic               hold_s1;
	logic               hold_s2;
	logic               v_s1;
	scan_state_t        st_next;
	scan_state_t        st_s1;
	logic [DUTY_W-1:0]  duty_rd;

	// The configuration registers are always ready to take a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_ticks_q <= CYCLE_TICKS_RESET;
			four_lines_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CYCLE_TICKS: cycle_ticks_q <= cfg_data[TICKS_W-1:0];
				CFG_FOUR_LINES:  four_lines_q  <= cfg_data[0];
				default:         four_lines_q  <= four_lines_q;
			endcase
		end
	end

	// The first stage only holds when everything ahead of it is full and stalled.
	assign hold_s1  = v_s1 && hold_s2;
	assign in_stall = hold_s1;
	assign accept   = in_valid && !in_stall;

	// Scan state is updated as each item is taken in.
	clps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (operation),
		.led_index    (led_index),
		.repeat_count (repeat_count),
		.cycle_ticks  (cycle_ticks_q),
		.four_lines   (four_lines_q),
		.st_next      (st_next)
	);

	// The duty of the slot position after this item is fetched in parallel with
	// any load it carries; a load to the same position is forwarded.
	clps_duty_mem u_duty_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && (operation == OP_LOAD)),
		.wr_addr (led_index),
		.wr_data (duty),
		.rd_en   (accept),
		.rd_addr (st_next.pos),
		.rd_data (duty_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!hold_s1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1 <= st_next;
		end
	end

	// Threshold compare, line decode and output register.
	clps_drive u_drive (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s1        (v_s1),
		.st_s1       (st_s1),
		.duty_s1     (duty_rd),
		.cycle_ticks (cycle_ticks_q),
		.four_lines  (four_lines_q),
		.out_stall   (out_stall),
		.hold_s2     (hold_s2),
		.out_valid   (out_valid),
		.line_high   (line_high),
		.line_enable (line_enable),
		.current_led (current_led),
		.frames_left (frames_left),
		.busy_res    (busy_res),
		.blanking    (blanking)
	);

endmodule

FILE: rtl/clps_checker.sv
`include "charlieplex_led_pwm_scanner_core_macros.svh"

module clps_checker import clps_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [LINE_W-1:0]     line_high,
	input logic [LINE_W-1:0]     line_enable,
	input logic [LED_W-1:0]      current_led,
	input logic [FRAMES_W-1:0]   frames_left,
	input logic                  busy_res,
	input logic                  blanking
);

	// A stalled result keeps its line drive and position.
	`CLPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(line_high) && $stable(line_enable) && $stable(current_led))

	// Input back-pressure only arises from a stalled result.
	`CLPS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

	// The closing blank frame drives nothing and has no frames left to play.
	`CLPS_ASSERT_NOW(a_blank_quiet, out_valid && blanking,
		busy_res && (frames_left == '0) && (line_enable == '0))

	// A lit LED drives exactly its anode high and its cathode low.
	`CLPS_ASSERT_NOW(a_one_led, out_valid && (line_enable != '0),
		($countones(line_enable) == 2) && ($countones(line_high) == 1)
		&& ((line_high & ~line_enable) == '0))

endmodule

bind charlieplex_led_pwm_scanner_core clps_checker u_clps_checker (.*);

FILE: verif/charlieplex_led_pwm_scanner_core_tb.sv
module charlieplex_led_pwm_scanner_core_tb;
	import clps_pkg::*;

	// Operation codes that the block does not define; they must leave the state alone.
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

	localparam int RANDOM_ITEMS    = 1650;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int MAX_PLAY_TICKS  = 400;

	// Line of the anode and of the cathode for each LED position.
	localparam logic [1:0] ANODE_LINE [MAX_LEDS]   = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2,
		2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd3};
	localparam logic [1:0] CATHODE_LINE [MAX_LEDS] = '{2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1,
		2'd3, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2};

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [LED_W-1:0]    led;
		logic [DUTY_W-1:0]   duty;
		logic [FRAMES_W-1:0] rep;
	} scan_item_t;

	typedef struct packed {
		logic [LINE_W-1:0]   hi;
		logic [LINE_W-1:0]   en;
		logic [LED_W-1:0]    cur;
		logic [FRAMES_W-1:0] frames;
		logic                busy;
		logic                blank;
	} scan_view_t;

	localparam scan_view_t ALL_DARK = '0;

	// A row of the directed plan is an item, a run of ticks (count in the repeat field)
	// or a register write. Item rows may carry a result typed in by hand.
	typedef enum logic [1:0] {ROW_ITEM, ROW_TICKS, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		scan_item_t            item;
		logic [CFG_IDX_W-1:0]  cfg_idx;
		logic [CFG_DATA_W-1:0] cfg_data;
		logic                  typed;
		scan_view_t            view;
	} plan_row_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [OP_W-1:0]       operation;
	logic [LED_W-1:0]      led_index;
	logic [DUTY_W-1:0]     duty;
	logic [FRAMES_W-1:0]   repeat_count;
	logic                  out_valid;
	logic                  out_stall;
	logic [LINE_W-1:0]     line_high;
	logic [LINE_W-1:0]     line_enable;
	logic [LED_W-1:0]      current_led;
	logic [FRAMES_W-1:0]   frames_left;
	logic                  busy_res;
	logic                  blanking;

	charlieplex_led_pwm_scanner_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.led_index    (led_index),
		.duty         (duty),
		.repeat_count (repeat_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_high    (line_high),
		.line_enable  (line_enable),
		.current_led  (current_led),
		.frames_left  (frames_left),
		.busy_res     (busy_res),
		.blanking     (blanking)
	);

	always #5 clk = ~clk;

	// The testbench's own copy of the scanner: duty store, scan state and registers.
	logic [DUTY_W-1:0]     duty_table [MAX_LEDS];
	logic [TIMER_BITS-1:0] slot_tmr    = '0;
	logic [LED_W-1:0]      slot_pos    = '0;
	logic [FRAMES_W-1:0]   frames_todo = '0;
	logic [1:0]            run_state   = MODE_IDLE;
	logic [LED_W-1:0]      held_pos    = '0;
	logic [TICKS_W-1:0]    cyc_ticks   = CYCLE_TICKS_RESET;
	logic                  four_mode   = 1'b1;

	// Results still owed by the block, oldest first.
	scan_view_t view_q [$];
	int         mismatch_count = 0;
	int         cycle_count    = 0;

	// The sender marks a directed row whose result is typed in by hand; the scoreboard
	// then queues that result instead of the predicted one.
	logic       fixed_on   = 1'b0;
	scan_view_t fixed_view = '0;

	// Burst shaping of the sender, and the request for one long hold-off of the receiver.
	int   burst_left   = 0;
	logic gaps_on      = 1'b1;
	logic hold_off_req = 1'b0;

	function automatic int leds_in_use();
		int n;
		n = four_mode ? (LAST_POS_FOUR + 1) : (LAST_POS_THREE + 1);
		return (n > MAX_LEDS) ? MAX_LEDS : n;
	endfunction

	// Line drive for one lit LED; every line is released for a position beyond the last.
	function automatic logic [2*LINE_W-1:0] led_drive(input logic [LED_W-1:0] led);
		logic [LINE_W-1:0] hi;
		logic [LINE_W-1:0] en;
		hi = '0;
		en = '0;
		if (int'(led) < leds_in_use()) begin
			hi[ANODE_LINE[led]]   = 1'b1;
			en[ANODE_LINE[led]]   = 1'b1;
			en[CATHODE_LINE[led]] = 1'b1;
		end
		return {hi, en};
	endfunction

	// Applies one accepted item to the scan state and returns the lines and status after it.
	function automatic scan_view_t scan_predict(input scan_item_t it);
		scan_view_t         v;
		logic [LEN_W-1:0]   slot_len;
		logic [DUTY_W-1:0]  d;
		logic [PROD_W-1:0]  on_ticks;
		case (it.op)
			OP_TICK: begin
				if (run_state == MODE_PLAY || run_state == MODE_BLANK) begin
					slot_len = (cyc_ticks == '0) ? LEN_W'(1) : LEN_W'(cyc_ticks);
					if (slot_len > (LEN_W'(1) << TIMER_BITS)) begin
						slot_len = LEN_W'(1) << TIMER_BITS;
					end
					slot_tmr = slot_tmr + 1'b1;
					if (slot_tmr == '0 || LEN_W'(slot_tmr) >= slot_len) begin
						slot_tmr = '0;
						slot_pos = slot_pos + 1'b1;
						if (int'(slot_pos) >= leds_in_use()) begin
							slot_pos = '0;
							if (run_state == MODE_PLAY) begin
								if (frames_todo == '0) begin
									run_state = MODE_BLANK;
								end else begin
									frames_todo = frames_todo - 1'b1;
								end
							end else begin
								run_state = MODE_IDLE;
							end
						end
					end
				end
			end
			OP_LOAD: begin
				if (int'(it.led) < MAX_LEDS) begin
					duty_table[it.led] = it.duty;
				end
			end
			OP_START: begin
				frames_todo = (it.rep == '0) ? '0 : it.rep - 1'b1;
				slot_tmr    = '0;
				slot_pos    = '0;
				run_state   = MODE_PLAY;
			end
			OP_HOLD: begin
				frames_todo = '0;
				slot_tmr    = '0;
				slot_pos    = '0;
				held_pos    = it.led;
				run_state   = (int'(it.led) < leds_in_use()) ? MODE_HOLD : MODE_IDLE;
			end
			OP_RELEASE: begin
				frames_todo = '0;
				slot_tmr    = '0;
				slot_pos    = '0;
				run_state   = MODE_IDLE;
			end
			default: begin
			end
		endcase

		v = '0;
		case (run_state)
			MODE_PLAY: begin
				d        = (int'(slot_pos) < MAX_LEDS) ? duty_table[slot_pos] : '0;
				on_ticks = PROD_W'(cyc_ticks) * PROD_W'(d);
				on_ticks = on_ticks / PROD_W'(FULL_DUTY);
				if (PROD_W'(slot_tmr) < on_ticks) begin
					{v.hi, v.en} = led_drive(slot_pos);
				end
				v.cur    = slot_pos;
				v.frames = frames_todo;
				v.busy   = 1'b1;
			end
			MODE_BLANK: begin
				v.cur   = slot_pos;
				v.busy  = 1'b1;
				v.blank = 1'b1;
			end
			MODE_HOLD: begin
				{v.hi, v.en} = led_drive(held_pos);
				v.cur        = held_pos;
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Scoreboard. Everything is sampled at the rising edge, while the stimulus moves on the
	// falling edge, so the order of processes within a step cannot matter. The result
	// transfer is checked before the input transfer of the same edge is predicted; as the
	// result passes through registered stages, the two never concern the same item.
	always @(posedge clk) begin : scoreboard
		scan_view_t want;
		scan_item_t taken;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (view_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected, got %h %h %0d %0d %b %b",
						$time, line_high, line_enable, current_led, frames_left, busy_res,
						blanking);
					mismatch_count++;
				end else begin
					want = view_q.pop_front();
					check_field("line_high", 32'(want.hi), 32'(line_high));
					check_field("line_enable", 32'(want.en), 32'(line_enable));
					check_field("current_led", 32'(want.cur), 32'(current_led));
					check_field("frames_left", 32'(want.frames), 32'(frames_left));
					check_field("busy_res", 32'(want.busy), 32'(busy_res));
					check_field("blanking", 32'(want.blank), 32'(blanking));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CYCLE_TICKS: cyc_ticks = cfg_data;
					CFG_FOUR_LINES:  four_mode = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				taken = {operation, led_index, duty, repeat_count};
				want  = scan_predict(taken);
				view_q.push_back(fixed_on ? fixed_view : want);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver. It stalls in one of several styles, each kept for a random stretch, and
	// on request holds off completely, long enough for the pipeline to fill up and the
	// block to stall its input.
	initial begin : receiver
		stall_style_t style;
		int           style_left;
		int           pat_ctr;
		style      = STALL_NONE;
		style_left = 0;
		pat_ctr    = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			pat_ctr++;
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (style_left == 0) begin
					style      = stall_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(20, 300);
				end
				style_left--;
				case (style)
					STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
					STALL_PERIODIC: out_stall <= ((pat_ctr % 7) < 3);
					default:        out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Offers one item from a falling edge, waits for its transfer and returns on the next
	// falling edge. Valid stays high into the next item while the burst lasts; when the
	// burst runs out and gaps are enabled, the sender drops valid for a random gap.
	task automatic offer_item(input scan_item_t it);
		in_valid     <= 1'b1;
		operation    <= it.op;
		led_index    <= it.led;
		duty         <= it.duty;
		repeat_count <= it.rep;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else if (gaps_on) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(0, 23);
		end
	endtask

	// Stops offering and waits until every owed result has come.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (view_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Directed plan. Results typed in are those that follow at once from reset, from the
	// LED map and from the extremes; the remaining rows go through the predictor.
	plan_row_t plan [$] = '{
		// Straight after reset a tick changes nothing.
		'{ROW_ITEM, '{OP_TICK, 4'd0, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1, ALL_DARK},
		// Holding the last LED, an index beyond every LED, then the first LED.
		'{ROW_ITEM, '{OP_HOLD, 4'd11, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1,
			'{4'h8, 4'hc, 4'd11, 16'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, '{OP_HOLD, 4'd15, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1, ALL_DARK},
		'{ROW_ITEM, '{OP_HOLD, 4'd0, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1,
			'{4'h1, 4'h3, 4'd0, 16'd0, 1'b0, 1'b0}},
		// An undefined operation with every field at its top leaves the hold in place.
		'{ROW_ITEM, '{OP_SPARE_C, 4'd15, 8'd255, 16'hffff}, CFG_CYCLE_TICKS, 16'd0, 1'b1,
			'{4'h1, 4'h3, 4'd0, 16'd0, 1'b0, 1'b0}},
		'{ROW_ITEM, '{OP_RELEASE, 4'd0, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1, ALL_DARK},
		'{ROW_ITEM, '{OP_SPARE_A, 4'd0, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1, ALL_DARK},
		// Full-duty loads to the first and last LED, loads beyond the store that must be dropped, and a half-duty load.
		'{ROW_ITEM, '{OP_LOAD, 4'd0, 8'd255, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_LOAD, 4'd11, 8'd255, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_LOAD, 4'd15, 8'd255, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_LOAD, 4'd12, 8'd255, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_LOAD, 4'd5, 8'd128, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		// One-tick slots: a repeat of zero plays one frame, then the blank frame.
		'{ROW_CFG, '0, CFG_CYCLE_TICKS, 16'd1, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_START, 4'd0, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_TICKS, '{OP_TICK, 4'd0, 8'd0, 16'd28}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		// Zero ticks per slot: one-tick slots that are never lit.
		'{ROW_CFG, '0, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_START, 4'd0, 8'd0, 16'd1}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_TICKS, '{OP_TICK, 4'd0, 8'd0, 16'd40}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		// Longest slot and largest repeat; a load during play, then a hold abandons it.
		'{ROW_CFG, '0, CFG_CYCLE_TICKS, 16'hffff, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_START, 4'd0, 8'd0, 16'hffff}, CFG_CYCLE_TICKS, 16'd0, 1'b1,
			'{4'h1, 4'h3, 4'd0, 16'hfffe, 1'b1, 1'b0}},
		'{ROW_TICKS, '{OP_TICK, 4'd0, 8'd0, 16'd4}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_LOAD, 4'd0, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_HOLD, 4'd3, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1,
			'{4'h4, 4'h5, 4'd3, 16'd0, 1'b0, 1'b0}},
		// A release abandons a running group.
		'{ROW_ITEM, '{OP_START, 4'd0, 8'd0, 16'd2}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_TICKS, '{OP_TICK, 4'd0, 8'd0, 16'd3}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_RELEASE, 4'd0, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1, ALL_DARK},
		// The line mode drops to three lines while the scan sits beyond the sixth LED.
		'{ROW_CFG, '0, CFG_CYCLE_TICKS, 16'd2, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_START, 4'd0, 8'd0, 16'd3}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_TICKS, '{OP_TICK, 4'd0, 8'd0, 16'd17}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_CFG, '0, CFG_FOUR_LINES, 16'hfffe, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_SPARE_B, 4'd0, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_TICKS, '{OP_TICK, 4'd0, 8'd0, 16'd12}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		// In three-line mode the seventh LED is out of range and the sixth is the last.
		'{ROW_ITEM, '{OP_HOLD, 4'd6, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1, ALL_DARK},
		'{ROW_ITEM, '{OP_HOLD, 4'd5, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1,
			'{4'h4, 4'h6, 4'd5, 16'd0, 1'b0, 1'b0}},
		// A held LED that the line mode then puts out of range.
		'{ROW_CFG, '0, CFG_FOUR_LINES, 16'h0001, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_HOLD, 4'd11, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b1,
			'{4'h8, 4'hc, 4'd11, 16'd0, 1'b0, 1'b0}},
		'{ROW_CFG, '0, CFG_FOUR_LINES, 16'h0000, 1'b0, ALL_DARK},
		'{ROW_ITEM, '{OP_SPARE_A, 4'd0, 8'd0, 16'd0}, CFG_CYCLE_TICKS, 16'd0, 1'b0, ALL_DARK},
		'{ROW_CFG, '0, CFG_FOUR_LINES, 16'h0001, 1'b0, ALL_DARK}
	};

	// Main stimulus: reset, the directed plan, then random phases with a fresh setting
	// of both registers each, written only once every owed result has come.
	initial begin : stimulus
		scan_item_t         it;
		int                 phase;
		int                 random_sent;
		int                 budget;
		int                 pick;
		longint             ticks_due;
		longint             slot_ticks;
		longint             frames_eff;
		logic [TICKS_W-1:0] next_ticks;
		logic               next_four;

		foreach (duty_table[i]) begin
			duty_table[i] = '0;
		end
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		operation    = OP_TICK;
		led_index    = '0;
		duty         = '0;
		repeat_count = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CFG: begin
					drain_results();
					write_reg(plan[i].cfg_idx, plan[i].cfg_data);
				end
				ROW_TICKS: begin
					fixed_on = 1'b0;
					repeat (int'(plan[i].item.rep)) begin
						it    = scan_item_t'(31'($urandom));
						it.op = OP_TICK;
						offer_item(it);
					end
				end
				default: begin
					fixed_on   = plan[i].typed;
					fixed_view = plan[i].view;
					offer_item(plan[i].item);
				end
			endcase
		end
		fixed_on = 1'b0;

		phase       = 0;
		random_sent = 0;
		ticks_due   = 0;
		while (random_sent < RANDOM_ITEMS) begin
			drain_results();
			case ($urandom_range(0, 15))
				0:       next_ticks = '0;
				1:       next_ticks = '1;
				2:       next_ticks = TICKS_W'($urandom_range(7, 65534));
				default: next_ticks = TICKS_W'($urandom_range(1, 6));
			endcase
			next_four = 1'($urandom_range(0, 1));
			write_reg(CFG_CYCLE_TICKS, next_ticks);
			write_reg(CFG_FOUR_LINES, {15'($urandom), next_four});
			slot_ticks = (next_ticks == '0) ? 1 : longint'(next_ticks);
			ticks_due  = 0;
			gaps_on    = ($urandom_range(0, 3) != 0);
			// In one phase the receiver holds off for a long time while the sender keeps
			// offering back to back, so that the block fills and stalls its input.
			if (phase == 1) begin
				gaps_on      = 1'b0;
				hold_off_req = 1'b1;
			end
			budget = $urandom_range(60, 220);
			if (budget > RANDOM_ITEMS - random_sent) begin
				budget = RANDOM_ITEMS - random_sent;
			end
			repeat (budget) begin
				it    = scan_item_t'(31'($urandom));
				it.op = OP_TICK;
				if (ticks_due > 0 && $urandom_range(0, 31) != 0) begin
					// A play in progress is mostly fed with ticks, now and then broken
					// into by another item.
					ticks_due--;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 40) begin
						it.op = OP_LOAD;
						case ($urandom_range(0, 3))
							0:       it.duty = '0;
							1:       it.duty = '1;
							default: it.duty = DUTY_W'($urandom);
						endcase
					end else if (pick < 70) begin
						it.op = OP_START;
						case ($urandom_range(0, 7))
							0:       it.rep = '1;
							1:       it.rep = FRAMES_W'($urandom);
							default: it.rep = FRAMES_W'($urandom_range(0, 3));
						endcase
						frames_eff = (it.rep == '0) ? 1 : longint'(it.rep);
						ticks_due  = (frames_eff + 1) * (next_four ? 12 : 6) * slot_ticks
							+ $urandom_range(0, 8);
						if (ticks_due > MAX_PLAY_TICKS) begin
							ticks_due = MAX_PLAY_TICKS;
						end
					end else if (pick < 80) begin
						it.op     = OP_HOLD;
						ticks_due = $urandom_range(0, 4);
					end else if (pick < 88) begin
						it.op = OP_RELEASE;
					end else if (pick < 94) begin
						it.op = OP_W'($urandom_range(int'(OP_SPARE_A), int'(OP_SPARE_C)));
					end
				end
				offer_item(it);
				random_sent++;
			end
			phase++;
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/clps_pkg.sv
rtl/clps_duty_mem.sv
rtl/clps_ctrl.sv
rtl/clps_drive.sv
rtl/charlieplex_led_pwm_scanner_core.sv
rtl/clps_checker.sv
verif/charlieplex_led_pwm_scanner_core_tb.sv
